// File: rtl/core/lrukv_pkg.sv
`timescale 1ns / 1ps

package lrukv_pkg;

  localparam int ENTRIES = 16;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int AGE_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
  localparam logic [CAP_W-1:0] CAP_MAX    = CAP_W'(ENTRIES);
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_SET = 1'b1;

  // Broadcast from the top level to every cell for the request in flight.
  typedef struct packed {
    logic             go;
    logic             is_set;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             hit;
    logic [AGE_W-1:0] old_age;
    logic             evict_en;
    logic [AGE_W-1:0] cap_m1;
  } lrukv_bcast_t;

  // Handed from each cell to its neighbor.
  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] rd_value;
    logic [AGE_W-1:0] age;
    logic             free;
    logic             evict;
  } lrukv_chain_t;

endpackage

// File: rtl/core/lrukv_cell.sv
`timescale 1ns / 1ps

module lrukv_cell
  import lrukv_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  lrukv_bcast_t bcast,
  input  lrukv_chain_t chain_in,
  output lrukv_chain_t chain_out,
  output logic         valid_mark
);

  logic             valid;
  logic [AGE_W-1:0] age;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;

  logic valid_next;
  logic [AGE_W-1:0] age_next;
  logic match, is_found, ev_here, free_here, is_slot, insert;

  assign match     = valid && (key == bcast.key);
  assign is_found  = match && !chain_in.found;
  assign insert    = bcast.is_set && !bcast.hit;
  assign ev_here   = bcast.evict_en && valid && (age >= bcast.cap_m1);
  assign free_here = !(valid && !ev_here);
  assign is_slot   = insert && free_here && !chain_in.free;

  always_comb begin
    chain_out.found    = chain_in.found | match;
    chain_out.rd_value = is_found ? value : chain_in.rd_value;
    chain_out.age      = is_found ? age : chain_in.age;
    chain_out.free     = chain_in.free | free_here;
    chain_out.evict    = chain_in.evict | ev_here;
  end

  assign valid_mark = valid;

  always_comb begin
    valid_next = valid;
    age_next   = age;
    if (bcast.hit) begin
      if (is_found) begin
        age_next = '0;
      end else if (valid && (age < bcast.old_age)) begin
        age_next = age + AGE_W'(1);
      end
    end else if (insert) begin
      if (is_slot) begin
        valid_next = 1'b1;
        age_next   = '0;
      end else if (ev_here) begin
        valid_next = 1'b0;
      end else if (valid) begin
        age_next = age + AGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      age   <= '0;
    end else if (bcast.go) begin
      valid <= valid_next;
      age   <= age_next;
    end
  end

  always_ff @(posedge clk) begin
    if (bcast.go) begin
      if (is_slot) begin
        key   <= bcast.key;
        value <= bcast.value;
      end else if (is_found && bcast.is_set) begin
        value <= bcast.value;
      end
    end
  end

endmodule

// File: rtl/core/lru_key_value_cache.sv
`timescale 1ns / 1ps
// Output: the result of a request is registered and shows in the cycle after acceptance.
// Throughput: one request per cycle while in_stall is low; every cell compares and updates in
// the accept cycle; match, value, free-slot and evict marks ripple down the row of sixteen cells.
// Reset (synchronous): all valid marks and ranks cleared at once, capacity set to 16,
// output empty; no clearing pass.

module lru_key_value_cache
  import lrukv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CAP_W-1:0]        capacity_in_use,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    req_type,
  input  logic signed [KEY_W-1:0] lookup_key,
  input  logic signed [VAL_W-1:0] write_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    hit,
  output logic signed [VAL_W-1:0] read_value,
  output logic                    evicted
);

  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] cap_eff;
  logic [CNT_W-1:0] count;
  logic [ENTRIES-1:0] valid_vec;
  logic accept;

  lrukv_bcast_t bcast;
  lrukv_chain_t chain [ENTRIES+1];

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= capacity_in_use;
    end
  end

  // Clamp capacity to 1..ENTRIES.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CAP_W'(1);
    end else if (capacity > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = capacity;
    end
  end

  assign count = CNT_W'($countones(valid_vec));
  assign chain[0] = '0;

  always_comb begin
    bcast.go       = accept;
    bcast.is_set   = (req_type == REQ_SET);
    bcast.key      = lookup_key;
    bcast.value    = write_value;
    bcast.hit      = chain[ENTRIES].found;
    bcast.old_age  = chain[ENTRIES].age;
    bcast.evict_en = (req_type == REQ_SET) && !chain[ENTRIES].found
                     && (CAP_W'(count) >= cap_eff);
    bcast.cap_m1   = AGE_W'(cap_eff - CAP_W'(1));
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lrukv_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .bcast      (bcast),
      .chain_in   (chain[g]),
      .chain_out  (chain[g+1]),
      .valid_mark (valid_vec[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the result while the output stalls.
  always_ff @(posedge clk) begin
    if (accept) begin
      hit        <= chain[ENTRIES].found;
      read_value <= (chain[ENTRIES].found && (req_type == REQ_GET))
                    ? chain[ENTRIES].rd_value : MISS_VALUE;
      evicted    <= chain[ENTRIES].evict;
    end
  end

endmodule
